// ----- rtl/blsm_pkg.sv -----
`timescale 1ns / 1ps

package blsm_pkg;

    localparam int ADC_W   = 12;
    localparam int RATIO_W = 10;
    localparam int MV_W    = 14;
    localparam int FRAC_W  = 8;
    localparam int PROD_W  = ADC_W + RATIO_W;

    // Register map, word index within the configuration space.
    localparam logic [1:0] REG_DIVIDER_RATIO = 2'd0;
    localparam logic [1:0] REG_CRITICAL_MV   = 2'd1;
    localparam logic [1:0] REG_LOW_MV        = 2'd2;
    localparam logic [1:0] REG_FULL_MV       = 2'd3;

    localparam logic [RATIO_W-1:0] DIVIDER_RATIO_RESET = 10'd801;
    localparam logic [MV_W-1:0]    CRITICAL_MV_RESET   = 14'd3000;
    localparam logic [MV_W-1:0]    LOW_MV_RESET        = 14'd3400;
    localparam logic [MV_W-1:0]    FULL_MV_RESET       = 14'd4000;

    localparam logic [MV_W-1:0] DROP_STEP_MV    = 14'd10;
    localparam logic [MV_W-1:0] RISE_STEP_MV    = 14'd50;
    localparam logic [MV_W-1:0] DROP_CEILING_MV = 14'd4000;
    localparam logic [1:0]      DROP_LIMIT      = 2'd3;

    localparam logic [1:0] LEVEL_NONE      = 2'd0;
    localparam logic [1:0] LEVEL_CRITICAL  = 2'd1;
    localparam logic [1:0] LEVEL_LOW       = 2'd2;
    localparam logic [1:0] LEVEL_RECOVERED = 2'd3;

    localparam logic [1:0] SUPPLY_NONE     = 2'd0;
    localparam logic [1:0] SUPPLY_LOST     = 2'd1;
    localparam logic [1:0] SUPPLY_RESTORED = 2'd2;

    typedef struct packed {
        logic [ADC_W-1:0] adc_mv;
        logic             read_ok;
    } sample_t;

    typedef struct packed {
        logic [MV_W-1:0] average_mv;
        logic [1:0]      level_event;
        logic [1:0]      supply_event;
        logic            usb_present;
        logic            warming;
    } result_t;

endpackage

// ----- rtl/battery_level_and_supply_loss_monitor_core.sv -----
`timescale 1ns / 1ps

// Battery level and supply loss monitor.
// Input channel (in_valid / in_stall / in_data) carries one ADC reading in
// millivolts and a read-ok flag per transfer. Output channel (out_valid /
// out_stall / out_data) returns exactly one result per input transfer.
// Thresholds and the divider ratio sit in an APB register file at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
// A small microcode table sequences a shared datapath: scale, store into the
// ring, accumulate the ring one entry per cycle, then a restoring divider
// that retires one quotient bit per cycle, and last the threshold check.
// The first RING_DEPTH samples only fill the ring and skip the accumulate,
// divide and check steps; they return a warm-up result with no mean. A new
// sample is taken once the sequencer is back in its idle step, even if the
// last result still sits in the output register; while the sequencer works
// on one sample, the input stalls and no new sample is taken.
// Reset clears the ring, the latches, the counters and the output register
// and loads the register defaults. While the receiver stalls, the finished
// result holds in the output register and the sequencer waits in its last
// step until the register frees.
module battery_level_and_supply_loss_monitor_core #(
    parameter int RING_DEPTH = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  blsm_pkg::sample_t        in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output blsm_pkg::result_t        out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int MV_W     = blsm_pkg::MV_W;
    localparam int IDX_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W    = MV_W + $clog2(RING_DEPTH);
    localparam int LOOP_MAX = (RING_DEPTH > SUM_W) ? RING_DEPTH : SUM_W;
    localparam int LOOP_W   = $clog2(LOOP_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_STORE,
        ST_ACC,
        ST_DIVINIT,
        ST_DIV,
        ST_CHECK,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_SCALE,
        OP_STORE,
        OP_ACC,
        OP_DIVINIT,
        OP_DIV,
        OP_CHECK,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WARM,
        COND_ACC_LOOP,
        COND_DIV_LOOP,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Microcode table: one control word per step.
    function automatic ctrl_t microcode(input step_t s);
        ctrl_t w;
        case (s)
            ST_IDLE:    w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: ST_SCALE};
            ST_SCALE:   w = '{op: OP_SCALE,   cond: COND_NEXT,     target: ST_STORE};
            ST_STORE:   w = '{op: OP_STORE,   cond: COND_WARM,     target: ST_EMIT};
            ST_ACC:     w = '{op: OP_ACC,     cond: COND_ACC_LOOP, target: ST_ACC};
            ST_DIVINIT: w = '{op: OP_DIVINIT, cond: COND_NEXT,     target: ST_DIV};
            ST_DIV:     w = '{op: OP_DIV,     cond: COND_DIV_LOOP, target: ST_DIV};
            ST_CHECK:   w = '{op: OP_CHECK,   cond: COND_NEXT,     target: ST_EMIT};
            ST_EMIT:    w = '{op: OP_EMIT,    cond: COND_WAIT_OUT, target: ST_IDLE};
            default:    w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: ST_SCALE};
        endcase
        return w;
    endfunction

    step_t                            pc_reg, pc_next;
    logic [LOOP_W-1:0]                lp_reg, lp_next;
    blsm_pkg::sample_t                in_reg, in_next;
    logic [MV_W-1:0]                  v_reg, v_next;
    logic [MV_W-1:0]                  ring_reg [RING_DEPTH];
    logic [MV_W-1:0]                  ring_next [RING_DEPTH];
    logic [IDX_W-1:0]                 ptr_reg, ptr_next;
    logic [CNT_W-1:0]                 warm_reg, warm_next;
    logic [MV_W-1:0]                  good_reg, good_next;
    logic                             good_valid_reg, good_valid_next;
    logic [MV_W-1:0]                  prev_reg, prev_next;
    logic                             low_l_reg, low_l_next;
    logic                             crit_l_reg, crit_l_next;
    logic                             lost_reg, lost_next;
    logic [1:0]                       drop_reg, drop_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [SUM_W-1:0]                 quo_reg, quo_next;
    logic [CNT_W-1:0]                 rem_reg, rem_next;
    blsm_pkg::result_t                res_reg, res_next;
    logic                             out_valid_reg, out_valid_next;
    blsm_pkg::result_t                out_reg, out_next;
    logic [blsm_pkg::RATIO_W-1:0]     ratio_reg, ratio_next;
    logic [MV_W-1:0]                  crit_mv_reg, crit_mv_next;
    logic [MV_W-1:0]                  low_mv_reg, low_mv_next;
    logic [MV_W-1:0]                  full_mv_reg, full_mv_next;

    ctrl_t                            ctrl;
    logic                             in_xfer;
    logic                             out_free;
    logic                             warming;
    logic                             cfg_write;
    logic [blsm_pkg::PROD_W-1:0]      product;
    logic [IDX_W:0]                   ptr_inc;
    logic [MV_W-1:0]                  ring_rd;
    logic [CNT_W:0]                   rem_shift;
    logic                             quo_bit;
    logic [MV_W-1:0]                  mean;
    logic                             crit_fire, low_fire, rec_fire;
    logic                             crit_l1, low_l1;
    logic                             both_pos, fell, rose;
    logic [1:0]                       drop_step;
    logic [1:0]                       level;
    logic [1:0]                       supply;
    logic                             lost_after;
    logic [1:0]                       drop_after;

    assign ctrl      = microcode(pc_reg);
    assign in_stall  = (pc_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign warming   = (warm_reg < CNT_W'(RING_DEPTH));
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign product   = blsm_pkg::PROD_W'(in_reg.adc_mv) * blsm_pkg::PROD_W'(ratio_reg);
    assign ptr_inc   = {1'b0, ptr_reg} + (IDX_W + 1)'(1);
    assign ring_rd   = ring_reg[lp_reg[IDX_W-1:0]];
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, cnt_reg});

    // Threshold and supply checks on the finished mean.
    always_comb
    begin
        mean      = (cnt_reg == '0) ? '0 : quo_reg[MV_W-1:0];
        crit_fire = (mean < crit_mv_reg) && !crit_l_reg;
        low_fire  = (mean < low_mv_reg) && (mean >= crit_mv_reg) && !low_l_reg;
        crit_l1   = crit_l_reg || crit_fire;
        low_l1    = low_l_reg || low_fire;
        rec_fire  = (mean >= full_mv_reg) && (crit_l1 || low_l1);
        if (rec_fire)
            level = blsm_pkg::LEVEL_RECOVERED;
        else if (low_fire)
            level = blsm_pkg::LEVEL_LOW;
        else if (crit_fire)
            level = blsm_pkg::LEVEL_CRITICAL;
        else
            level = blsm_pkg::LEVEL_NONE;

        both_pos = (prev_reg != '0) && (mean != '0);
        fell     = (prev_reg > mean) && ((prev_reg - mean) > blsm_pkg::DROP_STEP_MV);
        rose     = (mean > prev_reg) && ((mean - prev_reg) > blsm_pkg::RISE_STEP_MV);
        if (fell && (mean < blsm_pkg::DROP_CEILING_MV))
            drop_step = (drop_reg < blsm_pkg::DROP_LIMIT) ? drop_reg + 2'd1 : drop_reg;
        else if (rose)
            drop_step = 2'd0;
        else
            drop_step = drop_reg;

        supply     = blsm_pkg::SUPPLY_NONE;
        lost_after = lost_reg;
        drop_after = drop_reg;
        if (both_pos)
        begin
            drop_after = drop_step;
            if ((drop_step >= blsm_pkg::DROP_LIMIT) && !lost_reg)
            begin
                supply     = blsm_pkg::SUPPLY_LOST;
                lost_after = 1'b1;
                drop_after = 2'd0;
            end
            else if (rose && lost_reg)
            begin
                supply     = blsm_pkg::SUPPLY_RESTORED;
                lost_after = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            blsm_pkg::REG_DIVIDER_RATIO: prdata = 32'(ratio_reg);
            blsm_pkg::REG_CRITICAL_MV:   prdata = 32'(crit_mv_reg);
            blsm_pkg::REG_LOW_MV:        prdata = 32'(low_mv_reg);
            blsm_pkg::REG_FULL_MV:       prdata = 32'(full_mv_reg);
            default:                     prdata = '0;
        endcase
    end

    // Datapath and sequencer next state.
    always_comb
    begin
        pc_next         = pc_reg;
        lp_next         = lp_reg;
        in_next         = in_reg;
        v_next          = v_reg;
        ring_next       = ring_reg;
        ptr_next        = ptr_reg;
        warm_next       = warm_reg;
        good_next       = good_reg;
        good_valid_next = good_valid_reg;
        prev_next       = prev_reg;
        low_l_next      = low_l_reg;
        crit_l_next     = crit_l_reg;
        lost_next       = lost_reg;
        drop_next       = drop_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ratio_next      = ratio_reg;
        crit_mv_next    = crit_mv_reg;
        low_mv_next     = low_mv_reg;
        full_mv_next    = full_mv_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_write)
        begin
            case (paddr[3:2])
                blsm_pkg::REG_DIVIDER_RATIO: ratio_next = pwdata[blsm_pkg::RATIO_W-1:0];
                blsm_pkg::REG_CRITICAL_MV:   crit_mv_next = pwdata[MV_W-1:0];
                blsm_pkg::REG_LOW_MV:        low_mv_next = pwdata[MV_W-1:0];
                blsm_pkg::REG_FULL_MV:       full_mv_next = pwdata[MV_W-1:0];
                default:                     ratio_next = ratio_reg;
            endcase
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_xfer)
                    in_next = in_data;
            end
            OP_SCALE:
            begin
                if (in_reg.read_ok)
                begin
                    v_next          = product[blsm_pkg::FRAC_W +: MV_W];
                    good_next       = product[blsm_pkg::FRAC_W +: MV_W];
                    good_valid_next = 1'b1;
                end
                else
                begin
                    v_next = good_valid_reg ? good_reg : '0;
                end
            end
            OP_STORE:
            begin
                lp_next  = '0;
                sum_next = '0;
                cnt_next = '0;
                if (warming)
                begin
                    ring_next[warm_reg[IDX_W-1:0]] = v_reg;
                    warm_next = warm_reg + CNT_W'(1);
                    res_next  = '{average_mv: '0,
                                  level_event: blsm_pkg::LEVEL_NONE,
                                  supply_event: blsm_pkg::SUPPLY_NONE,
                                  usb_present: !lost_reg,
                                  warming: 1'b1};
                end
                else
                begin
                    ring_next[ptr_reg] = v_reg;
                    ptr_next = (ptr_inc >= (IDX_W + 1)'(RING_DEPTH)) ? '0 : ptr_inc[IDX_W-1:0];
                end
            end
            OP_ACC:
            begin
                if (ring_rd != '0)
                begin
                    sum_next = sum_reg + SUM_W'(ring_rd);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                lp_next = lp_reg + LOOP_W'(1);
            end
            OP_DIVINIT:
            begin
                quo_next = sum_reg;
                rem_next = '0;
                lp_next  = '0;
            end
            OP_DIV:
            begin
                // Restoring division, one quotient bit per step.
                if (quo_bit)
                    rem_next = rem_shift[CNT_W-1:0] - cnt_reg;
                else
                    rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], quo_bit};
                lp_next  = lp_reg + LOOP_W'(1);
            end
            OP_CHECK:
            begin
                crit_l_next = rec_fire ? 1'b0 : crit_l1;
                low_l_next  = rec_fire ? 1'b0 : low_l1;
                lost_next   = lost_after;
                drop_next   = drop_after;
                prev_next   = mean;
                res_next    = '{average_mv: mean,
                                level_event: level,
                                supply_event: supply,
                                usb_present: !lost_after,
                                warming: 1'b0};
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase

        case (ctrl.cond)
            COND_NEXT:     pc_next = step_t'(pc_reg + 3'd1);
            COND_WAIT_IN:  pc_next = in_xfer ? ctrl.target : pc_reg;
            COND_WARM:     pc_next = warming ? ctrl.target : step_t'(pc_reg + 3'd1);
            COND_ACC_LOOP: pc_next = (lp_reg == LOOP_W'(RING_DEPTH - 1)) ?
                                     step_t'(pc_reg + 3'd1) : ctrl.target;
            COND_DIV_LOOP: pc_next = (lp_reg == LOOP_W'(SUM_W - 1)) ?
                                     step_t'(pc_reg + 3'd1) : ctrl.target;
            COND_WAIT_OUT: pc_next = out_free ? ctrl.target : pc_reg;
            default:       pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= ST_IDLE;
            lp_reg         <= '0;
            in_reg         <= '0;
            v_reg          <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
            ptr_reg        <= '0;
            warm_reg       <= '0;
            good_reg       <= '0;
            good_valid_reg <= 1'b0;
            prev_reg       <= '0;
            low_l_reg      <= 1'b0;
            crit_l_reg     <= 1'b0;
            lost_reg       <= 1'b0;
            drop_reg       <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            ratio_reg      <= blsm_pkg::DIVIDER_RATIO_RESET;
            crit_mv_reg    <= blsm_pkg::CRITICAL_MV_RESET;
            low_mv_reg     <= blsm_pkg::LOW_MV_RESET;
            full_mv_reg    <= blsm_pkg::FULL_MV_RESET;
        end
        else
        begin
            pc_reg         <= pc_next;
            lp_reg         <= lp_next;
            in_reg         <= in_next;
            v_reg          <= v_next;
            ring_reg       <= ring_next;
            ptr_reg        <= ptr_next;
            warm_reg       <= warm_next;
            good_reg       <= good_next;
            good_valid_reg <= good_valid_next;
            prev_reg       <= prev_next;
            low_l_reg      <= low_l_next;
            crit_l_reg     <= crit_l_next;
            lost_reg       <= lost_next;
            drop_reg       <= drop_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            quo_reg        <= quo_next;
            rem_reg        <= rem_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            ratio_reg      <= ratio_next;
            crit_mv_reg    <= crit_mv_next;
            low_mv_reg     <= low_mv_next;
            full_mv_reg    <= full_mv_next;
        end
    end

    // A saturated drop count is only ever left standing once loss is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drop_reg == blsm_pkg::DROP_LIMIT) |-> lost_reg)
        else $error("drop counter saturated without latched supply loss");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (pc_reg == ST_SCALE))
        else $error("sequencer did not start after an input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.warming) |->
            ((out_data.level_event == blsm_pkg::LEVEL_NONE) &&
             (out_data.supply_event == blsm_pkg::SUPPLY_NONE) &&
             (out_data.average_mv == '0)))
        else $error("warm-up result carries a mean or an event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.supply_event == blsm_pkg::SUPPLY_LOST)) |->
            !out_data.usb_present)
        else $error("usb lost reported while usb still shown present");

endmodule
